>>> rtl/pdv_pkg.sv
// Shared types, constants and helpers for the pose difference velocity block.
// Used by pose_difference_velocity; no dependencies.
package pdv_pkg;

  localparam int STAMP_W = 63;
  localparam int POS_W   = 32;
  localparam int QUAT_W  = 16;
  localparam int RATE_W  = 32;

  typedef logic        [STAMP_W-1:0] stamp_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [RATE_W-1:0]  rate_t;

  localparam int ACC_W   = 98;
  localparam int MB_W    = 33;
  localparam int DQ_W    = 80;
  localparam int REM_W   = 63;
  localparam int SQ_W    = 100;
  localparam int ROOT_W  = 50;
  localparam int SREM_W  = 52;
  localparam int CW      = 34;
  localparam int ANG_W   = 33;
  localparam int ROT_W   = 68;
  localparam int QR_W    = 34;
  localparam int CQ_W    = 36;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 50;

  localparam logic [29:0]        NS_PER_S    = 30'd1000000000;
  localparam logic [60:0]        ONE_SQ      = 61'h1000_0000_0000_0000;
  localparam logic [60:0]        AXIS_EPS    = 61'd2560;
  localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [1:0] QX = 2'd0;
  localparam logic [1:0] QY = 2'd1;
  localparam logic [1:0] QZ = 2'd2;
  localparam logic [1:0] QW = 2'd3;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic       minus;
  } qterm_t;

  typedef struct packed {
    logic [RATE_W-1:0] val;
    logic              flag;
  } sat_t;

  // Terms of conj(q_prev) * q_cur; component 0 is w, then x, y, z.
  function automatic qterm_t qterm(logic [1:0] comp, logic [1:0] term);
    qterm_t r;
    case ({comp, term})
      4'h0:    r = '{QW, QW, 1'b0};
      4'h1:    r = '{QX, QX, 1'b0};
      4'h2:    r = '{QY, QY, 1'b0};
      4'h3:    r = '{QZ, QZ, 1'b0};
      4'h4:    r = '{QW, QX, 1'b0};
      4'h5:    r = '{QX, QW, 1'b1};
      4'h6:    r = '{QY, QZ, 1'b1};
      4'h7:    r = '{QZ, QY, 1'b0};
      4'h8:    r = '{QW, QY, 1'b0};
      4'h9:    r = '{QX, QZ, 1'b0};
      4'hA:    r = '{QY, QW, 1'b1};
      4'hB:    r = '{QZ, QX, 1'b1};
      4'hC:    r = '{QW, QZ, 1'b0};
      4'hD:    r = '{QX, QY, 1'b1};
      4'hE:    r = '{QY, QX, 1'b0};
      4'hF:    r = '{QZ, QW, 1'b1};
      default: r = '{QW, QW, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [29:0] cordic_atan(logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic [QUAT_W:0] qmag(logic [QUAT_W-1:0] a);
    logic [QUAT_W:0] e;
    e = {a[QUAT_W-1], a};
    return a[QUAT_W-1] ? (~e + 17'd1) : e;
  endfunction

  function automatic sat_t sat32(logic [DQ_W-1:0] q, logic neg);
    sat_t r;
    if (neg) begin
      if (q > 80'h8000_0000) r = '{32'h8000_0000, 1'b1};
      else                   r = '{~q[31:0] + 32'd1, 1'b0};
    end else begin
      if (q > 80'h7FFF_FFFF) r = '{32'h7FFF_FFFF, 1'b1};
      else                   r = '{q[31:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> rtl/pose_difference_velocity.sv
// Velocity from consecutive timestamped poses: speed and rotation rate.
// Bit-serial multiply, divide and square root units plus a CORDIC; uses pdv_pkg.
//
//  channel | signals                                          | dir
//  input   | in_valid, in_stall, stamp_ns, pos_*, quat_*      | in
//  output  | out_valid, out_stall, out_stamp_ns, speed,       | out
//          | rate_x/y/z, zero_interval, saturated             |
//
// One pose at a time; the longest work is in the serial divider (80 steps a run,
// up to seven runs) and the shift-add multiplier (one bit per cycle).
// Zero interval or first pose after reset: no arithmetic, all rates zero.
// Reset clears the stored pose to identity and forgets it.
// A finished result waits in the output register while the next pose is taken.
module pose_difference_velocity (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdv_pkg::stamp_t     stamp_ns,
  input  pdv_pkg::pos_t       pos_x,
  input  pdv_pkg::pos_t       pos_y,
  input  pdv_pkg::pos_t       pos_z,
  input  pdv_pkg::quat_t      quat_x,
  input  pdv_pkg::quat_t      quat_y,
  input  pdv_pkg::quat_t      quat_z,
  input  pdv_pkg::quat_t      quat_w,
  output logic                out_valid,
  input  logic                out_stall,
  output pdv_pkg::stamp_t     out_stamp_ns,
  output pdv_pkg::rate_t      speed,
  output pdv_pkg::rate_t      rate_x,
  output pdv_pkg::rate_t      rate_y,
  output pdv_pkg::rate_t      rate_z,
  output logic                zero_interval,
  output logic                saturated
);
  import pdv_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_POSMUL  = 4'd1;
  localparam logic [3:0] S_POSSQRT = 4'd2;
  localparam logic [3:0] S_SPDMUL  = 4'd3;
  localparam logic [3:0] S_SPDDIV  = 4'd4;
  localparam logic [3:0] S_QMUL    = 4'd5;
  localparam logic [3:0] S_WSQ     = 4'd6;
  localparam logic [3:0] S_SSQRT   = 4'd7;
  localparam logic [3:0] S_CORD    = 4'd8;
  localparam logic [3:0] S_RMUL1   = 4'd9;
  localparam logic [3:0] S_RDIV1   = 4'd10;
  localparam logic [3:0] S_RMUL2   = 4'd11;
  localparam logic [3:0] S_RDIV2   = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  logic [3:0] state;
  logic       ld;
  logic [1:0] k;
  logic [1:0] t;
  logic [6:0] cnt;

  logic   have;
  stamp_t prev_stamp;
  pos_t   prev_pos [3];
  quat_t  prev_q   [4];
  stamp_t cur_stamp;
  pos_t   cur_pos  [3];
  quat_t  cur_q    [4];

  logic [STAMP_W-1:0] gap;
  logic               neg;
  logic               zero_r;
  logic               satf;
  rate_t              res_speed;
  rate_t              res_rate [3];

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] ma;
  logic [MB_W-1:0]  mb;
  logic             msub;

  logic [DQ_W-1:0]  dq;
  logic [REM_W-1:0] drem;
  logic [REM_W-1:0] dden;

  logic [SQ_W-1:0]   sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [SREM_W-1:0] sq_rem;

  logic signed [CW-1:0] cx, cy, cz;
  logic [ANG_W-1:0]     ang;
  logic                 near;
  logic [QR_W-1:0]      qr [4];
  logic [ROT_W-1:0]     rot;
  logic                 cneg;

  // serial multiply
  logic [ACC_W-1:0] m_sum;
  assign m_sum = msub ? (acc - ma) : (acc + ma);

  // serial divide
  logic [REM_W:0]  d_rsh;
  logic            d_ge;
  logic [REM_W:0]  d_diff;
  logic [REM_W-1:0] d_rem_nx;
  logic [DQ_W-1:0] d_q_nx;
  sat_t            d_sat;
  assign d_rsh    = {drem, dq[DQ_W-1]};
  assign d_ge     = d_rsh >= {1'b0, dden};
  assign d_diff   = d_rsh - {1'b0, dden};
  assign d_rem_nx = d_ge ? d_diff[REM_W-1:0] : d_rsh[REM_W-1:0];
  assign d_q_nx   = {dq[DQ_W-2:0], d_ge};
  assign d_sat    = sat32(d_q_nx, (state == S_SPDDIV) ? neg : (cneg ^ neg));

  // serial square root, two radicand bits a step
  logic [SREM_W+1:0] s_rsh;
  logic [SREM_W+1:0] s_trial;
  logic              s_ge;
  logic [SREM_W+1:0] s_diff;
  assign s_rsh   = {sq_rem, sq_v[SQ_W-1 -: 2]};
  assign s_trial = {2'b00, sq_root, 2'b01};
  assign s_ge    = s_rsh >= s_trial;
  assign s_diff  = s_rsh - s_trial;

  // operand forms
  logic [POS_W:0] dpos;
  logic [POS_W:0] dmag;
  assign dpos = {cur_pos[k][POS_W-1], cur_pos[k]} - {prev_pos[k][POS_W-1], prev_pos[k]};
  assign dmag = dpos[POS_W] ? (~dpos + 33'd1) : dpos;

  qterm_t          term;
  quat_t           qa, qb;
  assign term = qterm(k, t);
  assign qa   = prev_q[term.a];
  assign qb   = cur_q[term.b];

  logic [QR_W-1:0] w_mag;
  logic [CQ_W-1:0] w_q30;
  logic [30:0]     wm;
  assign w_mag = qr[0][QR_W-1] ? (~qr[0] + 34'd1) : qr[0];
  assign w_q30 = {w_mag, 2'b00};
  assign wm    = (w_q30 > {5'b0, ONE_Q30}) ? ONE_Q30 : w_q30[30:0];

  logic [1:0]      kc;
  logic [QR_W-1:0] c_mag;
  logic [CQ_W-1:0] cq;
  assign kc    = k + 2'd1;
  assign c_mag = qr[kc][QR_W-1] ? (~qr[kc] + 34'd1) : qr[kc];
  assign cq    = {c_mag, 2'b00};

  logic [60:0] s2_w;
  logic [30:0] s_root;
  assign s2_w   = ONE_SQ - acc[60:0];
  assign s_root = sq_root[30:0];

  // CORDIC vectoring step
  logic signed [CW-1:0] c_xs, c_ys, c_step;
  logic signed [CW-1:0] cx_nx, cy_nx, cz_nx;
  logic signed [CW-1:0] zc;
  assign c_xs   = cx >>> cnt[4:0];
  assign c_ys   = cy >>> cnt[4:0];
  assign c_step = {4'b0, cordic_atan(cnt[4:0])};

  always_comb begin
    cx_nx = cx;
    cy_nx = cy;
    cz_nx = cz;
    if (cy > 0) begin
      cx_nx = cx + c_ys;
      cy_nx = cy - c_xs;
      cz_nx = cz + c_step;
    end else if (cy < 0) begin
      cx_nx = cx - c_ys;
      cy_nx = cy + c_xs;
      cz_nx = cz - c_step;
    end
    if (cz_nx < 0)           zc = '0;
    else if (cz_nx > PI_Q30) zc = PI_Q30;
    else                     zc = cz_nx;
  end

  logic zero_now;
  assign zero_now = !have || (stamp_ns == prev_stamp);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ld         <= 1'b0;
      k          <= '0;
      t          <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
      have       <= 1'b0;
      prev_stamp <= '0;
      prev_pos[0] <= '0;
      prev_pos[1] <= '0;
      prev_pos[2] <= '0;
      prev_q[QX] <= '0;
      prev_q[QY] <= '0;
      prev_q[QZ] <= '0;
      prev_q[QW] <= 16'sd16384;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_stamp  <= stamp_ns;
            cur_pos[0] <= pos_x;
            cur_pos[1] <= pos_y;
            cur_pos[2] <= pos_z;
            cur_q[QX]  <= quat_x;
            cur_q[QY]  <= quat_y;
            cur_q[QZ]  <= quat_z;
            cur_q[QW]  <= quat_w;
            neg        <= stamp_ns < prev_stamp;
            gap        <= (stamp_ns < prev_stamp) ? (prev_stamp - stamp_ns)
                                                  : (stamp_ns - prev_stamp);
            zero_r     <= zero_now;
            satf       <= 1'b0;
            res_speed  <= '0;
            res_rate[0] <= '0;
            res_rate[1] <= '0;
            res_rate[2] <= '0;
            k          <= '0;
            t          <= '0;
            ld         <= 1'b1;
            state      <= zero_now ? S_FIN : S_POSMUL;
          end
        end

        S_POSMUL, S_SPDMUL, S_QMUL, S_WSQ, S_RMUL1, S_RMUL2: begin
          if (state == S_RMUL1 && near) begin
            rot   <= (k == 2'd0) ? {{(ROT_W-ANG_W){1'b0}}, ang} : '0;
            cneg  <= 1'b0;
            ld    <= 1'b1;
            state <= S_RMUL2;
          end else if (ld) begin
            ld   <= 1'b0;
            msub <= (state == S_QMUL) && (qa[QUAT_W-1] ^ qb[QUAT_W-1] ^ term.minus);
            case (state)
              S_POSMUL: begin
                ma <= {{(ACC_W-POS_W-1){1'b0}}, dmag};
                mb <= dmag;
                if (k == 2'd0) acc <= '0;
              end
              S_SPDMUL: begin
                ma  <= {{(ACC_W-ROOT_W){1'b0}}, sq_root};
                mb  <= {3'b0, NS_PER_S};
                acc <= '0;
              end
              S_QMUL: begin
                ma   <= {{(ACC_W-QUAT_W-1){1'b0}}, qmag(qa)};
                mb   <= {{(MB_W-QUAT_W-1){1'b0}}, qmag(qb)};
                if (t == 2'd0) acc <= '0;
              end
              S_WSQ: begin
                ma  <= {{(ACC_W-31){1'b0}}, wm};
                mb  <= {2'b0, wm};
                acc <= '0;
              end
              S_RMUL1: begin
                ma  <= {{(ACC_W-CQ_W){1'b0}}, cq};
                mb  <= ang;
                acc <= '0;
              end
              default: begin
                ma  <= {{(ACC_W-ROT_W){1'b0}}, rot};
                mb  <= {3'b0, NS_PER_S};
                acc <= '0;
              end
            endcase
          end else if (mb != '0) begin
            if (mb[0]) acc <= m_sum;
            ma <= {ma[ACC_W-2:0], 1'b0};
            mb <= {1'b0, mb[MB_W-1:1]};
          end else begin
            ld <= 1'b1;
            case (state)
              S_POSMUL: begin
                if (k == 2'd2) state <= S_POSSQRT;
                else           k <= k + 2'd1;
              end
              S_SPDMUL: state <= S_SPDDIV;
              S_QMUL: begin
                t <= t + 2'd1;
                if (t == 2'd3) begin
                  qr[k] <= acc[QR_W-1:0];
                  k     <= k + 2'd1;
                  if (k == 2'd3) state <= S_WSQ;
                end
              end
              S_WSQ: begin
                near  <= s2_w < AXIS_EPS;
                state <= S_SSQRT;
              end
              S_RMUL1: state <= S_RDIV1;
              default: state <= S_RDIV2;
            endcase
          end
        end

        S_POSSQRT, S_SSQRT: begin
          if (ld) begin
            ld      <= 1'b0;
            cnt     <= '0;
            sq_root <= '0;
            sq_rem  <= '0;
            if (state == S_POSSQRT) sq_v <= {acc[67:0], 32'b0};
            else                    sq_v <= {{(SQ_W-61){1'b0}}, s2_w};
          end else begin
            sq_v    <= {sq_v[SQ_W-3:0], 2'b00};
            sq_root <= {sq_root[ROOT_W-2:0], s_ge};
            sq_rem  <= s_ge ? s_diff[SREM_W-1:0] : s_rsh[SREM_W-1:0];
            cnt     <= cnt + 7'd1;
            if (cnt == 7'(SQRT_STEPS - 1)) begin
              ld    <= 1'b1;
              state <= (state == S_POSSQRT) ? S_SPDMUL : S_CORD;
            end
          end
        end

        S_SPDDIV, S_RDIV1, S_RDIV2: begin
          if (ld) begin
            ld   <= 1'b0;
            cnt  <= '0;
            drem <= '0;
            case (state)
              S_SPDDIV: begin
                dq   <= acc[95:16];
                dden <= gap;
              end
              S_RDIV1: begin
                dq   <= {{(DQ_W-ROT_W){1'b0}}, acc[ROT_W-1:0]};
                dden <= {{(REM_W-31){1'b0}}, s_root};
              end
              default: begin
                dq   <= acc[93:14];
                dden <= gap;
              end
            endcase
          end else begin
            dq   <= d_q_nx;
            drem <= d_rem_nx;
            cnt  <= cnt + 7'd1;
            if (cnt == 7'(DQ_W - 1)) begin
              ld <= 1'b1;
              case (state)
                S_SPDDIV: begin
                  res_speed <= d_sat.val;
                  satf      <= satf | d_sat.flag;
                  k         <= '0;
                  t         <= '0;
                  state     <= S_QMUL;
                end
                S_RDIV1: begin
                  rot   <= d_q_nx[ROT_W-1:0];
                  cneg  <= qr[kc][QR_W-1];
                  state <= S_RMUL2;
                end
                default: begin
                  res_rate[k] <= d_sat.val;
                  satf        <= satf | d_sat.flag;
                  k           <= k + 2'd1;
                  state       <= (k == 2'd2) ? S_FIN : S_RMUL1;
                end
              endcase
            end
          end
        end

        S_CORD: begin
          if (ld) begin
            ld  <= 1'b0;
            cnt <= '0;
            if (qr[0][QR_W-1]) begin
              cx <= {3'b0, s_root};
              cy <= {3'b0, wm};
              cz <= HALF_PI_Q30;
            end else begin
              cx <= {3'b0, wm};
              cy <= {3'b0, s_root};
              cz <= '0;
            end
          end else begin
            cx  <= cx_nx;
            cy  <= cy_nx;
            cz  <= cz_nx;
            cnt <= cnt + 7'd1;
            if (cnt == 7'(CORDIC_STEPS - 1)) begin
              ang   <= {zc[31:0], 1'b0};
              k     <= '0;
              ld    <= 1'b1;
              state <= S_RMUL1;
            end
          end
        end

        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            out_stamp_ns  <= cur_stamp;
            speed         <= res_speed;
            rate_x        <= res_rate[0];
            rate_y        <= res_rate[1];
            rate_z        <= res_rate[2];
            zero_interval <= zero_r;
            saturated     <= satf;
            have          <= 1'b1;
            prev_stamp    <= cur_stamp;
            prev_pos[0]   <= cur_pos[0];
            prev_pos[1]   <= cur_pos[1];
            prev_pos[2]   <= cur_pos[2];
            prev_q[QX]    <= cur_q[QX];
            prev_q[QY]    <= cur_q[QY];
            prev_q[QZ]    <= cur_q[QZ];
            prev_q[QW]    <= cur_q[QW];
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_interval |->
      speed == 0 && rate_x == 0 && rate_y == 0 && rate_z == 0 && !saturated)
    else $error("zero interval result carries nonzero rates");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after taking a pose");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPDDIV || state == S_RDIV1 || state == S_RDIV2) && !ld |-> dden != '0)
    else $error("serial divide started with zero divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_POSSQRT || state == S_SSQRT) && !ld |->
      sq_rem <= {1'b0, sq_root, 1'b0})
    else $error("square root remainder out of bound");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for pose_difference_velocity: random and directed poses,
// with a bit-exact speed and rotation-rate predictor in a small scoreboard class.
// Depends on pdv_pkg and the pose_difference_velocity RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdv_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam int RANDOM_POSES = 850;

  typedef struct {
    stamp_t stamp;
    pos_t px, py, pz;
    quat_t qx, qy, qz, qw;
  } pose_t;

  typedef struct {
    stamp_t stamp;
    rate_t speed, rx, ry, rz;
    logic zero, sat;
  } velocity_t;

  class velocity_scoreboard;
    velocity_t pending[$];
    pose_t last;
    bit have_last;
    int errors;

    function new();
      have_last = 0;
      errors = 0;
      last = '{stamp: '0, px: '0, py: '0, pz: '0, qx: '0, qy: '0, qz: '0, qw: 16'sd16384};
    endfunction

    function automatic logic [63:0] root(logic [127:0] v);
      logic [63:0] r, t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
    endfunction

    function automatic longint half_angle(longint y, longint x);
      longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};
      longint z, nx, stp, t;
      z = 0;
      if (x < 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end
      for (int i = 0; i < 30; i++) begin
        stp = (i < 10) ? atan_tab[i] : (64'sd1 <<< (30 - i));
        if (y > 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); x = nx; z += stp;
        end else if (y < 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); x = nx; z -= stp;
        end
      end
      if (z < 0) z = 0;
      if (z > PI_Q30) z = PI_Q30;
      return z;
    endfunction

    function automatic rate_t clip(logic [127:0] q, bit neg, inout logic flag);
      if (neg) begin
        if (q > 128'h8000_0000) begin flag = 1; return 32'h8000_0000; end
        return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) begin flag = 1; return 32'h7FFF_FFFF; end
      return q[31:0];
    endfunction

    function void note(pose_t p);
      velocity_t e;
      logic [127:0] sum, q, rot[3];
      logic [63:0] gap, d, wm, s2, s, ang;
      longint dp[3], rw, rc[3];
      longint ax, ay, az, aw, bx, by, bz, bw;
      bit neg, cneg[3];
      e = '{stamp: p.stamp, speed: '0, rx: '0, ry: '0, rz: '0, zero: 1, sat: 0};
      if (have_last && p.stamp != last.stamp) begin
        e.zero = 0;
        neg = p.stamp < last.stamp;
        gap = neg ? 64'(last.stamp - p.stamp) : 64'(p.stamp - last.stamp);
        dp[0] = longint'(p.px) - longint'(last.px);
        dp[1] = longint'(p.py) - longint'(last.py);
        dp[2] = longint'(p.pz) - longint'(last.pz);
        sum = '0;
        for (int k = 0; k < 3; k++) begin
          d = dp[k] < 0 ? -dp[k] : dp[k];
          sum += {64'd0, d} * {64'd0, d};
        end
        sum = sum << 32;
        q = ({64'd0, root(sum)} * 128'd1000000000) >> 16;
        e.speed = clip(q / gap, neg, e.sat);
        aw = last.qw; ax = last.qx; ay = last.qy; az = last.qz;
        bw = p.qw; bx = p.qx; by = p.qy; bz = p.qz;
        rw    = aw * bw + ax * bx + ay * by + az * bz;
        rc[0] = aw * bx - ax * bw - ay * bz + az * by;
        rc[1] = aw * by + ax * bz - ay * bw - az * bx;
        rc[2] = aw * bz - ax * by + ay * bx - az * bw;
        wm = (rw < 0 ? -rw : rw) << 2;
        if (wm > (64'd1 << 30)) wm = 64'd1 << 30;
        s2 = (64'd1 << 60) - wm * wm;
        s = root({64'd0, s2});
        ang = 2 * half_angle(longint'(s), rw < 0 ? -longint'(wm) : longint'(wm));
        for (int k = 0; k < 3; k++) begin
          rot[k] = '0;
          cneg[k] = 0;
        end
        if (s2 < 64'd2560) rot[0] = {64'd0, ang};
        else
          for (int k = 0; k < 3; k++) begin
            d = (rc[k] < 0 ? -rc[k] : rc[k]) << 2;
            rot[k] = ({64'd0, d} * {64'd0, ang}) / {64'd0, s};
            cneg[k] = rc[k] < 0;
          end
        e.rx = clip(((rot[0] * 128'd1000000000) >> 14) / gap, cneg[0] != neg, e.sat);
        e.ry = clip(((rot[1] * 128'd1000000000) >> 14) / gap, cneg[1] != neg, e.sat);
        e.rz = clip(((rot[2] * 128'd1000000000) >> 14) / gap, cneg[2] != neg, e.sat);
      end
      pending.push_back(e);
      last = p;
      have_last = 1;
    endfunction

    function void check(velocity_t a);
      velocity_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, stamp %0d", a.stamp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.stamp !== e.stamp) begin
        $error("out_stamp_ns exp %0d got %0d", e.stamp, a.stamp); errors++;
      end
      if (a.speed !== e.speed) begin
        $error("speed exp %0d got %0d", e.speed, a.speed); errors++;
      end
      if (a.rx !== e.rx) begin
        $error("rate_x exp %0d got %0d", e.rx, a.rx); errors++;
      end
      if (a.ry !== e.ry) begin
        $error("rate_y exp %0d got %0d", e.ry, a.ry); errors++;
      end
      if (a.rz !== e.rz) begin
        $error("rate_z exp %0d got %0d", e.rz, a.rz); errors++;
      end
      if (a.zero !== e.zero) begin
        $error("zero_interval exp %0b got %0b", e.zero, a.zero); errors++;
      end
      if (a.sat !== e.sat) begin
        $error("saturated exp %0b got %0b", e.sat, a.sat); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  stamp_t stamp_ns = '0;
  pos_t pos_x = '0, pos_y = '0, pos_z = '0;
  quat_t quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic out_valid, out_stall = 0;
  stamp_t out_stamp_ns;
  rate_t speed, rate_x, rate_y, rate_z;
  logic zero_interval, saturated;

  velocity_scoreboard sb = new();
  pose_t poses[$];
  longint cycles = 0;
  int stall_mode = 0;

  pose_difference_velocity uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
    if (out_valid && !out_stall)
      sb.check('{stamp: out_stamp_ns, speed: speed, rx: rate_x, ry: rate_y, rz: rate_z,
                 zero: zero_interval, sat: saturated});
  end

  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(7) == 0);
      2: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= ((cycles / 40) % 2 == 1);
    endcase
  end

  task automatic add(stamp_t st, pos_t x, pos_t y, pos_t z,
                     quat_t a, quat_t b, quat_t c, quat_t w);
    poses.push_back('{stamp: st, px: x, py: y, pz: z, qx: a, qy: b, qz: c, qw: w});
  endtask

  task automatic send(pose_t p);
    @(negedge clk);
    in_valid <= 1;
    stamp_ns <= p.stamp;
    pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
    quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz; quat_w <= p.qw;
    do @(posedge clk); while (in_stall);
    sb.note(p);
  endtask

  function automatic quat_t nudge(quat_t v);
    int t;
    t = int'(v) + int'($urandom_range(2000)) - 1000;
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return quat_t'(t);
  endfunction

  initial begin
    pose_t cur;
    int burst;
    add(1000, 0, 0, 0, 0, 0, 0, 16384);
    add(1000, 65536, 0, 0, 0, 0, 0, 16384);
    add(1000001000, 65536, 0, 0, 0, 0, 0, 16384);
    add(2000001000, 131072, -65536, 32768, 0, 0, 0, -16384);
    add(1000, 0, 0, 0, 11585, 0, 0, 11585);
    add(1001, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16384, 0, 0, 0);
    add(1002, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, -16384, 0, 0);
    add(5001002, 0, 0, 0, 0, 0, 16384, 0);
    add(9001002, 0, 0, 0, -16384, -16384, -16384, -16384);
    add(63'h7FFFFFFFFFFFFFFF, 100, 200, 300, 16384, 16384, 16384, 16384);
    add(0, -100, -200, -300, 0, 0, 0, 16384);
    add(0, 5, 5, 5, 0, 0, 0, 16384);
    add(1, 0, 0, 0, 0, 0, 0, -16384);
    add(2, 0, 0, 0, 8192, 8192, 8192, 8192);
    add(20000002, 1000, 0, 0, 100, -50, 25, 16383);
    add(10000002, 0, 0, 0, -16384, 0, 0, 1);
    repeat (11) @(negedge clk);
    rst <= 0;
    foreach (poses[i]) send(poses[i]);
    cur = poses[poses.size() - 1];
    burst = 0;
    for (int n = 0; n < RANDOM_POSES; n++) begin
      if ($urandom_range(9) == 0) begin
        cur.stamp = stamp_t'({$urandom, $urandom});
        cur.px = $urandom; cur.py = $urandom; cur.pz = $urandom;
        cur.qx = quat_t'(int'($urandom_range(32768)) - 16384);
        cur.qy = quat_t'(int'($urandom_range(32768)) - 16384);
        cur.qz = quat_t'(int'($urandom_range(32768)) - 16384);
        cur.qw = quat_t'(int'($urandom_range(32768)) - 16384);
      end else begin
        case ($urandom_range(19))
          0: ;
          1: cur.stamp = cur.stamp - $urandom_range(100000000);
          2: cur.stamp = cur.stamp + $urandom_range(1000);
          default: cur.stamp = cur.stamp + 1 + $urandom_range(200000000);
        endcase
        cur.px = cur.px + int'($urandom_range(2000000)) - 1000000;
        cur.py = cur.py + int'($urandom_range(2000000)) - 1000000;
        cur.pz = cur.pz + int'($urandom_range(2000000)) - 1000000;
        cur.qx = nudge(cur.qx); cur.qy = nudge(cur.qy);
        cur.qz = nudge(cur.qz); cur.qw = nudge(cur.qw);
      end
      if (burst == 0) begin
        burst = 1 + $urandom_range(20);
        @(negedge clk);
        in_valid <= 0;
        repeat ($urandom_range(30)) @(negedge clk);
      end
      burst--;
      send(cur);
    end
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

>>> filelist.f
rtl/pdv_pkg.sv
rtl/pose_difference_velocity.sv
tb/testbench.sv
